FILE: hdl/ppcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pair collision resolver: shared package
// Word and fraction widths, register defaults and indexes, phase codes, the
// pipelined square root and divider sizes, stream widths and pipeline depth.
// ----------------------------------------------------------------------------
package ppcr_pkg;

    // Fixed-point format of every word on the stream.
    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;

    // Configuration registers.
    localparam int CD_W       = 31;
    localparam int REST_W     = 17;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_DISTANCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOLID_RESTITUTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAS_RESTITUTION   = 2'd2;

    localparam logic [CD_W-1:0]   CD_RESET         = 31'd131072;
    localparam logic [REST_W-1:0] SOLID_REST_RESET = 17'd58982;
    localparam logic [REST_W-1:0] GAS_REST_RESET   = 17'd6554;

    // Particle phase codes.
    localparam logic [1:0] PHASE_SOLID  = 2'd0;
    localparam logic [1:0] PHASE_LIQUID = 2'd1;
    localparam logic [1:0] PHASE_GAS    = 2'd2;

    // Square root unit: one result bit per stage.
    localparam int SQ_IN_W  = 62;
    localparam int SQ_OUT_W = 31;
    localparam int SQ_STEPS = 31;
    localparam int SQ_REM_W = 34;

    // Divider unit: one quotient bit per stage, quotient at most 1.0 in Q16.
    localparam int DIV_W     = 34;
    localparam int DIV_Q_W   = 17;
    localparam int DIV_STEPS = 17;

    // Stream widths.
    localparam int IN_TDATA_W  = 328;
    localparam int OUT_TDATA_W = 264;

    // Register stages: three in front, the root, the root fix-up, the
    // quotients, and seven stages of products and updates.
    localparam int PIPE_DEPTH = 3 + SQ_STEPS + 1 + DIV_STEPS + 7;

endpackage

FILE: hdl/particle_pair_collision_resolver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pair collision resolver
// Contact test, normal, restitution impulse and position correction for one
// pair of round particles per transaction, all in Q16.16 fixed point.
//
//   Channel   Direction  Signals                       Content
//   s_*       in         s_tvalid s_tready s_tdata     one particle pair
//   m_*       out        m_tvalid m_tready m_tdata     updated pair and flags
//   cfg_*     in         cfg_we cfg_index cfg_data     register writes
//
// A new pair is taken in every cycle while the output is not held. The depth
// is set by the square root (31 stages, one root bit each) and the four
// dividers (17 stages, one quotient bit each).
// Reset clears the valid bits and loads the register defaults.
// When the output is held, every stage holds with it and s_tready falls.
// ----------------------------------------------------------------------------
module particle_pair_collision_resolver (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // pos_a_x, pos_a_y, vel_a_x, vel_a_y, mass_a, phase_a,
    // pos_b_x, pos_b_y, vel_b_x, vel_b_y, mass_b, phase_b, zero fill
    input  logic [ppcr_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // new_pos_a_x, new_pos_a_y, new_vel_a_x, new_vel_a_y, new_pos_b_x,
    // new_pos_b_y, new_vel_b_x, new_vel_b_y, in_contact, impulse_applied, zero fill
    output logic [ppcr_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_we,
    input  logic [ppcr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppcr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ppcr_pkg::*;

    typedef struct packed {
        logic signed [WORD_W-1:0] pos_a_x;
        logic signed [WORD_W-1:0] pos_a_y;
        logic signed [WORD_W-1:0] vel_a_x;
        logic signed [WORD_W-1:0] vel_a_y;
        logic        [WORD_W-1:0] mass_a;
        logic        [1:0]        phase_a;
        logic signed [WORD_W-1:0] pos_b_x;
        logic signed [WORD_W-1:0] pos_b_y;
        logic signed [WORD_W-1:0] vel_b_x;
        logic signed [WORD_W-1:0] vel_b_y;
        logic        [WORD_W-1:0] mass_b;
        logic        [1:0]        phase_b;
    } item_t;

    // Side data that rides alongside the square root.
    typedef struct packed {
        item_t           item;
        logic            contact;
        logic            sq_zero;
        logic [CD_W-1:0] adx;
        logic [CD_W-1:0] ady;
        logic [WORD_W:0] msum;
    } root_side_t;

    // Side data that rides alongside the dividers.
    typedef struct packed {
        item_t           item;
        logic            contact;
        logic [CD_W-1:0] pen;
        logic            msum_zero;
    } div_side_t;

    // Control flags of the back end.
    typedef struct packed {
        logic contact;
        logic ss;
        logic gasy;
        logic liq;
        logic nx_neg;
        logic ny_neg;
    } ctl_t;

    localparam int PROD_W = WORD_W + 1 + DIV_Q_W + 1;
    localparam int RS_W   = PROD_W + 1;
    localparam int S_W    = RS_W - FRAC_W;
    localparam int OPE_W  = REST_W + 1;
    localparam int MOV_W  = S_W;
    localparam int SUM_W  = MOV_W + 2;

    localparam logic [DIV_Q_W-1:0] HALF_SHARE = DIV_Q_W'(1 << (FRAC_W - 1));
    localparam logic [OPE_W-1:0]   ONE_Q16    = OPE_W'(1 << FRAC_W);

    // ------------------------------------------------------------------
    // Saturating update of a word by a magnitude.
    function automatic logic [WORD_W-1:0] sat_move(
        input logic signed [WORD_W-1:0] base,
        input logic        [MOV_W-1:0]  amount,
        input logic                     add
    );
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] m;
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        b  = SUM_W'(base);
        m  = $signed({2'b00, amount});
        r  = add ? (b + m) : (b - m);
        hi = SUM_W'($signed({1'b0, {(WORD_W-1){1'b1}}}));
        lo = SUM_W'($signed({1'b1, {(WORD_W-1){1'b0}}}));
        if (r > hi)
        begin
            r = hi;
        end
        else if (r < lo)
        begin
            r = lo;
        end
        return r[WORD_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [CD_W-1:0]   cd_reg;
    logic [REST_W-1:0] solid_rest_reg;
    logic [REST_W-1:0] gas_rest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg         <= CD_RESET;
            solid_rest_reg <= SOLID_REST_RESET;
            gas_rest_reg   <= GAS_REST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONTACT_DISTANCE:  cd_reg         <= cfg_data[CD_W-1:0];
                CFG_SOLID_RESTITUTION: solid_rest_reg <= cfg_data[REST_W-1:0];
                CFG_GAS_RESTITUTION:   gas_rest_reg   <= cfg_data[REST_W-1:0];
                default:               ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance and valid bits.
    logic adv;
    logic vld_reg [PIPE_DEPTH];

    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack, offsets, box test and mass sum.
    item_t              in_item;
    logic signed [32:0] dx_c;
    logic signed [32:0] dy_c;
    logic [32:0]        adx_c;
    logic [32:0]        ady_c;
    logic               near_c;

    assign in_item.pos_a_x = s_tdata[31:0];
    assign in_item.pos_a_y = s_tdata[63:32];
    assign in_item.vel_a_x = s_tdata[95:64];
    assign in_item.vel_a_y = s_tdata[127:96];
    assign in_item.mass_a  = s_tdata[159:128];
    assign in_item.phase_a = s_tdata[161:160];
    assign in_item.pos_b_x = s_tdata[193:162];
    assign in_item.pos_b_y = s_tdata[225:194];
    assign in_item.vel_b_x = s_tdata[257:226];
    assign in_item.vel_b_y = s_tdata[289:258];
    assign in_item.mass_b  = s_tdata[321:290];
    assign in_item.phase_b = s_tdata[323:322];

    assign dx_c   = 33'(in_item.pos_b_x) - 33'(in_item.pos_a_x);
    assign dy_c   = 33'(in_item.pos_b_y) - 33'(in_item.pos_a_y);
    assign adx_c  = dx_c[32] ? (33'd0 - dx_c) : dx_c;
    assign ady_c  = dy_c[32] ? (33'd0 - dy_c) : dy_c;
    assign near_c = (adx_c < {2'b00, cd_reg}) && (ady_c < {2'b00, cd_reg});

    item_t           item1_reg;
    logic [CD_W-1:0] adx1_reg;
    logic [CD_W-1:0] ady1_reg;
    logic            near1_reg;
    logic [WORD_W:0] msum1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item1_reg <= in_item;
            adx1_reg  <= near_c ? adx_c[CD_W-1:0] : '0;
            ady1_reg  <= near_c ? ady_c[CD_W-1:0] : '0;
            near1_reg <= near_c;
            msum1_reg <= {1'b0, in_item.mass_a} + {1'b0, in_item.mass_b};
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares of the offsets and of the contact distance.
    item_t              item2_reg;
    logic [CD_W-1:0]    adx2_reg;
    logic [CD_W-1:0]    ady2_reg;
    logic               near2_reg;
    logic [WORD_W:0]    msum2_reg;
    logic [SQ_IN_W-1:0] sqx2_reg;
    logic [SQ_IN_W-1:0] sqy2_reg;
    logic [SQ_IN_W-1:0] cdsq2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item2_reg <= item1_reg;
            adx2_reg  <= adx1_reg;
            ady2_reg  <= ady1_reg;
            near2_reg <= near1_reg;
            msum2_reg <= msum1_reg;
            sqx2_reg  <= {31'd0, adx1_reg} * {31'd0, adx1_reg};
            sqy2_reg  <= {31'd0, ady1_reg} * {31'd0, ady1_reg};
            cdsq2_reg <= {31'd0, cd_reg} * {31'd0, cd_reg};
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared distance against squared contact distance.
    logic [SQ_IN_W:0]   sq_c;
    logic               contact_c;
    logic [SQ_IN_W-1:0] sq_in_c;
    root_side_t         side3_reg;
    logic [SQ_IN_W-1:0] sq3_reg;

    assign sq_c      = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
    assign contact_c = near2_reg && (sq_c < {1'b0, cdsq2_reg});
    assign sq_in_c   = contact_c ? sq_c[SQ_IN_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side3_reg.item    <= item2_reg;
            side3_reg.contact <= contact_c;
            side3_reg.sq_zero <= (sq_in_c == '0);
            side3_reg.adx     <= adx2_reg;
            side3_reg.ady     <= ady2_reg;
            side3_reg.msum    <= msum2_reg;
            sq3_reg           <= sq_in_c;
        end
    end

    // ------------------------------------------------------------------
    // Square root, with the side data delayed alongside.
    logic [SQ_OUT_W-1:0] root_c;
    root_side_t          root_line_reg [SQ_STEPS];

    ppcr_sqrt u_sqrt (
        .clk      (clk),
        .en       (adv),
        .x_in     (sq3_reg),
        .root_out (root_c)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            root_line_reg[0] <= side3_reg;
            for (int i = 1; i < SQ_STEPS; i++)
            begin
                root_line_reg[i] <= root_line_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: distance fix-up, penetration and divider operands.
    root_side_t      rs_side;
    logic [CD_W-1:0] dist_c;
    div_side_t       side4_reg;
    logic [DIV_W-1:0] nx_num_reg;
    logic [DIV_W-1:0] ny_num_reg;
    logic [DIV_W-1:0] dist_den_reg;
    logic [DIV_W-1:0] fa_num_reg;
    logic [DIV_W-1:0] fb_num_reg;
    logic [DIV_W-1:0] msum_den_reg;

    assign rs_side = root_line_reg[SQ_STEPS-1];
    assign dist_c  = rs_side.sq_zero ? cd_reg : root_c;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side4_reg.item      <= rs_side.item;
            side4_reg.contact   <= rs_side.contact;
            side4_reg.pen       <= cd_reg - dist_c;
            side4_reg.msum_zero <= (rs_side.msum == '0);
            nx_num_reg          <= {3'b000, rs_side.adx};
            ny_num_reg          <= {3'b000, rs_side.ady};
            dist_den_reg        <= {3'b000, dist_c};
            fa_num_reg          <= {2'b00, rs_side.item.mass_b};
            fb_num_reg          <= {2'b00, rs_side.item.mass_a};
            msum_den_reg        <= {1'b0, rs_side.msum};
        end
    end

    // ------------------------------------------------------------------
    // Normal components and mass shares.
    logic [DIV_Q_W-1:0] nx_q;
    logic [DIV_Q_W-1:0] ny_q;
    logic [DIV_Q_W-1:0] fa_q;
    logic [DIV_Q_W-1:0] fb_q;
    div_side_t          div_line_reg [DIV_STEPS];

    ppcr_div u_div_nx (
        .clk (clk), .en (adv), .num (nx_num_reg), .den (dist_den_reg), .quo (nx_q)
    );
    ppcr_div u_div_ny (
        .clk (clk), .en (adv), .num (ny_num_reg), .den (dist_den_reg), .quo (ny_q)
    );
    ppcr_div u_div_fa (
        .clk (clk), .en (adv), .num (fa_num_reg), .den (msum_den_reg), .quo (fa_q)
    );
    ppcr_div u_div_fb (
        .clk (clk), .en (adv), .num (fb_num_reg), .den (msum_den_reg), .quo (fb_q)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_line_reg[0] <= side4_reg;
            for (int i = 1; i < DIV_STEPS; i++)
            begin
                div_line_reg[i] <= div_line_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: signs, phase classes and relative velocity.
    div_side_t          ds_side;
    item_t              item5_reg;
    ctl_t               ctl5_reg;
    logic [CD_W-1:0]    pen5_reg;
    logic [DIV_Q_W-1:0] nxm5_reg;
    logic [DIV_Q_W-1:0] nym5_reg;
    logic [DIV_Q_W-1:0] fa5_reg;
    logic [DIV_Q_W-1:0] fb5_reg;
    logic signed [WORD_W:0] dvx5_reg;
    logic signed [WORD_W:0] dvy5_reg;
    logic pha_s, pha_l, pha_g, phb_s, phb_l, phb_g;

    assign ds_side = div_line_reg[DIV_STEPS-1];
    assign pha_s   = (ds_side.item.phase_a == PHASE_SOLID);
    assign pha_l   = (ds_side.item.phase_a == PHASE_LIQUID);
    assign pha_g   = (ds_side.item.phase_a == PHASE_GAS);
    assign phb_s   = (ds_side.item.phase_b == PHASE_SOLID);
    assign phb_l   = (ds_side.item.phase_b == PHASE_LIQUID);
    assign phb_g   = (ds_side.item.phase_b == PHASE_GAS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item5_reg        <= ds_side.item;
            ctl5_reg.contact <= ds_side.contact;
            ctl5_reg.ss      <= pha_s && phb_s;
            ctl5_reg.gasy    <= (pha_g && phb_g) || (pha_s && phb_g) || (pha_g && phb_s);
            ctl5_reg.liq     <= (pha_l && (phb_s || phb_l || phb_g))
                             || (phb_l && (pha_s || pha_l || pha_g));
            ctl5_reg.nx_neg  <= (ds_side.item.pos_b_x < ds_side.item.pos_a_x);
            ctl5_reg.ny_neg  <= (ds_side.item.pos_b_y < ds_side.item.pos_a_y);
            pen5_reg         <= ds_side.pen;
            nxm5_reg         <= nx_q;
            nym5_reg         <= ny_q;
            fa5_reg          <= ds_side.msum_zero ? HALF_SHARE : fa_q;
            fb5_reg          <= ds_side.msum_zero ? HALF_SHARE : fb_q;
            dvx5_reg         <= (WORD_W+1)'(ds_side.item.vel_b_x)
                              - (WORD_W+1)'(ds_side.item.vel_a_x);
            dvy5_reg         <= (WORD_W+1)'(ds_side.item.vel_b_y)
                              - (WORD_W+1)'(ds_side.item.vel_a_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: relative velocity projected on the normal, per axis.
    logic signed [DIV_Q_W:0] nxs_c;
    logic signed [DIV_Q_W:0] nys_c;
    item_t              item6_reg;
    ctl_t               ctl6_reg;
    logic [CD_W-1:0]    pen6_reg;
    logic [DIV_Q_W-1:0] nxm6_reg;
    logic [DIV_Q_W-1:0] nym6_reg;
    logic [DIV_Q_W-1:0] fa6_reg;
    logic [DIV_Q_W-1:0] fb6_reg;
    logic signed [PROD_W-1:0] px6_reg;
    logic signed [PROD_W-1:0] py6_reg;

    assign nxs_c = ctl5_reg.nx_neg ? -$signed({1'b0, nxm5_reg}) : $signed({1'b0, nxm5_reg});
    assign nys_c = ctl5_reg.ny_neg ? -$signed({1'b0, nym5_reg}) : $signed({1'b0, nym5_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item6_reg <= item5_reg;
            ctl6_reg  <= ctl5_reg;
            pen6_reg  <= pen5_reg;
            nxm6_reg  <= nxm5_reg;
            nym6_reg  <= nym5_reg;
            fa6_reg   <= fa5_reg;
            fb6_reg   <= fb5_reg;
            px6_reg   <= PROD_W'(dvx5_reg) * PROD_W'(nxs_c);
            py6_reg   <= PROD_W'(dvy5_reg) * PROD_W'(nys_c);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: closing test, closing speed and restitution factor.
    logic signed [RS_W-1:0] rs_c;
    logic [RS_W-1:0]        neg_rs_c;
    logic                   closing_c;
    item_t              item7_reg;
    ctl_t               ctl7_reg;
    logic [CD_W-1:0]    pen7_reg;
    logic [DIV_Q_W-1:0] nxm7_reg;
    logic [DIV_Q_W-1:0] nym7_reg;
    logic [DIV_Q_W-1:0] fa7_reg;
    logic [DIV_Q_W-1:0] fb7_reg;
    logic [S_W-1:0]     s7_reg;
    logic [OPE_W-1:0]   ope7_reg;
    logic               closing7_reg;

    assign rs_c      = RS_W'(px6_reg) + RS_W'(py6_reg);
    assign neg_rs_c  = RS_W'(0) - rs_c;
    assign closing_c = ctl6_reg.contact && (ctl6_reg.ss || ctl6_reg.gasy) && rs_c[RS_W-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item7_reg    <= item6_reg;
            ctl7_reg     <= ctl6_reg;
            pen7_reg     <= pen6_reg;
            nxm7_reg     <= nxm6_reg;
            nym7_reg     <= nym6_reg;
            fa7_reg      <= fa6_reg;
            fb7_reg      <= fb6_reg;
            s7_reg       <= neg_rs_c[RS_W-1:FRAC_W];
            ope7_reg     <= ONE_Q16 + {1'b0, ctl6_reg.ss ? solid_rest_reg : gas_rest_reg};
            closing7_reg <= closing_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: impulse magnitude t = s * (1 + e).
    logic [S_W+OPE_W-1:0] t_prod_c;
    item_t              item8_reg;
    ctl_t               ctl8_reg;
    logic [CD_W-1:0]    pen8_reg;
    logic [DIV_Q_W-1:0] nxm8_reg;
    logic [DIV_Q_W-1:0] nym8_reg;
    logic [DIV_Q_W-1:0] fa8_reg;
    logic [DIV_Q_W-1:0] fb8_reg;
    logic [S_W-1:0]     t8_reg;
    logic               closing8_reg;

    assign t_prod_c = (S_W+OPE_W)'(s7_reg) * (S_W+OPE_W)'(ope7_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item8_reg    <= item7_reg;
            ctl8_reg     <= ctl7_reg;
            pen8_reg     <= pen7_reg;
            nxm8_reg     <= nxm7_reg;
            nym8_reg     <= nym7_reg;
            fa8_reg      <= fa7_reg;
            fb8_reg      <= fb7_reg;
            t8_reg       <= t_prod_c[S_W+FRAC_W-1:FRAC_W];
            closing8_reg <= closing7_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: mass-weighted impulse and position shares.
    logic [S_W+DIV_Q_W-1:0]  ta_prod_c;
    logic [S_W+DIV_Q_W-1:0]  tb_prod_c;
    logic [CD_W+DIV_Q_W-1:0] ca_prod_c;
    logic [CD_W+DIV_Q_W-1:0] cb_prod_c;
    logic [CD_W-1:0]         half_pen_c;
    item_t              item9_reg;
    ctl_t               ctl9_reg;
    logic [DIV_Q_W-1:0] nxm9_reg;
    logic [DIV_Q_W-1:0] nym9_reg;
    logic [S_W-1:0]     ta9_reg;
    logic [S_W-1:0]     tb9_reg;
    logic [CD_W-1:0]    pa9_reg;
    logic [CD_W-1:0]    pb9_reg;
    logic               move_vel9_reg;
    logic               move_pos9_reg;

    assign ta_prod_c  = (S_W+DIV_Q_W)'(t8_reg) * (S_W+DIV_Q_W)'(fa8_reg);
    assign tb_prod_c  = (S_W+DIV_Q_W)'(t8_reg) * (S_W+DIV_Q_W)'(fb8_reg);
    assign ca_prod_c  = (CD_W+DIV_Q_W)'(pen8_reg) * (CD_W+DIV_Q_W)'(fa8_reg);
    assign cb_prod_c  = (CD_W+DIV_Q_W)'(pen8_reg) * (CD_W+DIV_Q_W)'(fb8_reg);
    assign half_pen_c = {1'b0, pen8_reg[CD_W-1:1]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item9_reg     <= item8_reg;
            ctl9_reg      <= ctl8_reg;
            nxm9_reg      <= nxm8_reg;
            nym9_reg      <= nym8_reg;
            ta9_reg       <= ta_prod_c[S_W+FRAC_W-1:FRAC_W];
            tb9_reg       <= tb_prod_c[S_W+FRAC_W-1:FRAC_W];
            pa9_reg       <= ctl8_reg.ss ? ca_prod_c[CD_W+FRAC_W:FRAC_W+1] : half_pen_c;
            pb9_reg       <= ctl8_reg.ss ? cb_prod_c[CD_W+FRAC_W:FRAC_W+1] : half_pen_c;
            move_vel9_reg <= closing8_reg;
            move_pos9_reg <= ctl8_reg.contact && ((ctl8_reg.ss && closing8_reg) || ctl8_reg.liq);
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: moves along each axis of the normal.
    logic [S_W+DIV_Q_W-1:0]  dvax_c, dvay_c, dvbx_c, dvby_c;
    logic [CD_W+DIV_Q_W-1:0] dpax_c, dpay_c, dpbx_c, dpby_c;
    item_t           item10_reg;
    ctl_t            ctl10_reg;
    logic [MOV_W-1:0] dvax10_reg, dvay10_reg, dvbx10_reg, dvby10_reg;
    logic [CD_W-1:0]  dpax10_reg, dpay10_reg, dpbx10_reg, dpby10_reg;
    logic             move_vel10_reg;
    logic             move_pos10_reg;

    assign dvax_c = (S_W+DIV_Q_W)'(ta9_reg) * (S_W+DIV_Q_W)'(nxm9_reg);
    assign dvay_c = (S_W+DIV_Q_W)'(ta9_reg) * (S_W+DIV_Q_W)'(nym9_reg);
    assign dvbx_c = (S_W+DIV_Q_W)'(tb9_reg) * (S_W+DIV_Q_W)'(nxm9_reg);
    assign dvby_c = (S_W+DIV_Q_W)'(tb9_reg) * (S_W+DIV_Q_W)'(nym9_reg);
    assign dpax_c = (CD_W+DIV_Q_W)'(pa9_reg) * (CD_W+DIV_Q_W)'(nxm9_reg);
    assign dpay_c = (CD_W+DIV_Q_W)'(pa9_reg) * (CD_W+DIV_Q_W)'(nym9_reg);
    assign dpbx_c = (CD_W+DIV_Q_W)'(pb9_reg) * (CD_W+DIV_Q_W)'(nxm9_reg);
    assign dpby_c = (CD_W+DIV_Q_W)'(pb9_reg) * (CD_W+DIV_Q_W)'(nym9_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item10_reg     <= item9_reg;
            ctl10_reg      <= ctl9_reg;
            dvax10_reg     <= dvax_c[MOV_W+FRAC_W-1:FRAC_W];
            dvay10_reg     <= dvay_c[MOV_W+FRAC_W-1:FRAC_W];
            dvbx10_reg     <= dvbx_c[MOV_W+FRAC_W-1:FRAC_W];
            dvby10_reg     <= dvby_c[MOV_W+FRAC_W-1:FRAC_W];
            dpax10_reg     <= dpax_c[CD_W+FRAC_W-1:FRAC_W];
            dpay10_reg     <= dpay_c[CD_W+FRAC_W-1:FRAC_W];
            dpbx10_reg     <= dpbx_c[CD_W+FRAC_W-1:FRAC_W];
            dpby10_reg     <= dpby_c[CD_W+FRAC_W-1:FRAC_W];
            move_vel10_reg <= move_vel9_reg;
            move_pos10_reg <= move_pos9_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: apply the moves with saturation into the output register.
    logic [OUT_TDATA_W-1:0] out_next;
    logic [OUT_TDATA_W-1:0] out_reg;
    logic                   nxn;
    logic                   nyn;

    assign nxn = ctl10_reg.nx_neg;
    assign nyn = ctl10_reg.ny_neg;

    always_comb
    begin
        out_next = '0;
        out_next[31:0] = move_pos10_reg
            ? sat_move(item10_reg.pos_a_x, MOV_W'(dpax10_reg), nxn) : item10_reg.pos_a_x;
        out_next[63:32] = move_pos10_reg
            ? sat_move(item10_reg.pos_a_y, MOV_W'(dpay10_reg), nyn) : item10_reg.pos_a_y;
        out_next[95:64] = move_vel10_reg
            ? sat_move(item10_reg.vel_a_x, dvax10_reg, nxn) : item10_reg.vel_a_x;
        out_next[127:96] = move_vel10_reg
            ? sat_move(item10_reg.vel_a_y, dvay10_reg, nyn) : item10_reg.vel_a_y;
        out_next[159:128] = move_pos10_reg
            ? sat_move(item10_reg.pos_b_x, MOV_W'(dpbx10_reg), !nxn) : item10_reg.pos_b_x;
        out_next[191:160] = move_pos10_reg
            ? sat_move(item10_reg.pos_b_y, MOV_W'(dpby10_reg), !nyn) : item10_reg.pos_b_y;
        out_next[223:192] = move_vel10_reg
            ? sat_move(item10_reg.vel_b_x, dvbx10_reg, !nxn) : item10_reg.vel_b_x;
        out_next[255:224] = move_vel10_reg
            ? sat_move(item10_reg.vel_b_y, dvby10_reg, !nyn) : item10_reg.vel_b_y;
        out_next[256] = ctl10_reg.contact;
        out_next[257] = move_vel10_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tdata = out_reg;

    // ------------------------------------------------------------------
    // Checks.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[257]) |-> m_tdata[256])
        else $error("impulse reported for a pair that is not in contact");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the output transaction is held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg[PIPE_DEPTH-2]))
        else $error("pipeline moved while the output was held");

endmodule

FILE: hdl/ppcr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root of a 62-bit value, one root bit per
// register stage. All stages advance together on the enable.
// ----------------------------------------------------------------------------
module ppcr_sqrt (
    input  logic                            clk,
    input  logic                            en,
    input  logic [ppcr_pkg::SQ_IN_W-1:0]    x_in,
    output logic [ppcr_pkg::SQ_OUT_W-1:0]   root_out
);
    import ppcr_pkg::*;

    logic [SQ_IN_W-1:0]  x_reg    [SQ_STEPS];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_STEPS];
    logic [SQ_OUT_W-1:0] root_reg [SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_step
            logic [SQ_IN_W-1:0]  x_prev;
            logic [SQ_REM_W-1:0] rem_prev;
            logic [SQ_OUT_W-1:0] root_prev;
            logic [SQ_REM_W-1:0] rem_shift;
            logic [SQ_REM_W-1:0] trial;
            logic                take;

            if (k == 0)
            begin : g_first
                assign x_prev    = x_in;
                assign rem_prev  = '0;
                assign root_prev = '0;
            end
            else
            begin : g_next
                assign x_prev    = x_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
            end

            // Bring down the next two bits and try the next root bit.
            assign rem_shift = {rem_prev[SQ_REM_W-3:0], x_prev[SQ_IN_W-1 -: 2]};
            assign trial     = {1'b0, root_prev, 2'b01};
            assign take      = (rem_shift >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[k]    <= {x_prev[SQ_IN_W-3:0], 2'b00};
                    rem_reg[k]  <= take ? (rem_shift - trial) : rem_shift;
                    root_reg[k] <= {root_prev[SQ_OUT_W-2:0], take};
                end
            end
        end
    endgenerate

    assign root_out = root_reg[SQ_STEPS-1];

endmodule

FILE: hdl/ppcr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Restoring division of a numerator no larger than the denominator, giving
// the quotient in Q1.16, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ppcr_div (
    input  logic                           clk,
    input  logic                           en,
    input  logic [ppcr_pkg::DIV_W-1:0]     num,
    input  logic [ppcr_pkg::DIV_W-1:0]     den,
    output logic [ppcr_pkg::DIV_Q_W-1:0]   quo
);
    import ppcr_pkg::*;

    logic [DIV_W-1:0]   rem_reg [DIV_STEPS];
    logic [DIV_W-1:0]   den_reg [DIV_STEPS];
    logic [DIV_Q_W-1:0] q_reg   [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [DIV_W-1:0]   rem_shift;
            logic [DIV_W-1:0]   den_prev;
            logic [DIV_Q_W-1:0] q_prev;
            logic               take;

            // The integer bit comes first, then one fraction bit per stage.
            if (k == 0)
            begin : g_first
                assign rem_shift = num;
                assign den_prev  = den;
                assign q_prev    = '0;
            end
            else
            begin : g_next
                assign rem_shift = {rem_reg[k-1][DIV_W-2:0], 1'b0};
                assign den_prev  = den_reg[k-1];
                assign q_prev    = q_reg[k-1];
            end

            assign take = (rem_shift >= den_prev);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_shift - den_prev) : rem_shift;
                    den_reg[k] <= den_prev;
                    q_reg[k]   <= {q_prev[DIV_Q_W-2:0], take};
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_STEPS-1];

endmodule

FILE: verif/particle_pair_collision_resolver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pair collision resolver: self-checking testbench
// A directed table of pairs runs first: far pairs, zero offsets, every phase
// combination, zero and extreme masses, and saturating pushes. Random pairs
// follow under several register settings. Every result transaction is checked
// field by field against the table's outcome or a fixed-point predictor of
// the contact response. Both stream sides idle at random, and the output is
// held off once for a long stretch so the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module particle_pair_collision_resolver_tb;
    import ppcr_pkg::*;

    localparam logic [1:0] PHASE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 70;
    localparam int STALL_LIMIT   = 3000;
    localparam int N_SETTINGS    = 6;
    localparam int PAIRS_PER_SET = 75;

    typedef struct {
        logic signed [31:0] pax, pay, vax, vay;
        logic [31:0]        ma;
        logic [1:0]         pha;
        logic signed [31:0] pbx, pby, vbx, vby;
        logic [31:0]        mb;
        logic [1:0]         phb;
    } pair_t;

    typedef struct {
        logic [31:0] w [8];
        logic        contact;
        logic        impulse;
    } outcome_t;

    typedef struct {
        pair_t    p;
        logic     typed;
        outcome_t res;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor copy of the registers.
    logic [CD_W-1:0]   contact_dist;
    logic [REST_W-1:0] rest_solid;
    logic [REST_W-1:0] rest_gas;

    outcome_t pending_outcomes[$];
    pair_t    offered_pair;
    logic     offered_typed;
    outcome_t offered_outcome;

    int  errors;
    int  quiet_cycles;
    int  recv_gap;
    int  hold_left;
    bit  no_idle;
    row_t directed_rows[$];

    string word_names [8] = '{"new_pos_a_x", "new_pos_a_y", "new_vel_a_x", "new_vel_a_y",
                              "new_pos_b_x", "new_pos_b_y", "new_vel_b_x", "new_vel_b_y"};

    particle_pair_collision_resolver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock and a single reset at the start.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Fixed-point helpers for the predictor.
    // ------------------------------------------------------------------------
    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? (64'd0 - longint'(v)) : longint'(v);
    endfunction

    // Product of two Q16.16 values on magnitudes, truncated toward zero.
    function automatic longint qmul(longint a, longint b);
        longint unsigned m;
        m = (magnitude(a) * magnitude(b)) >> FRAC_W;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_word(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic outcome_t unchanged_pair(pair_t p, logic contact);
        outcome_t o;
        o.w = '{p.pax, p.pay, p.vax, p.vay, p.pbx, p.pby, p.vbx, p.vby};
        o.contact = contact;
        o.impulse = 1'b0;
        return o;
    endfunction

    // Contact test, normal, impulse and position correction for one pair.
    function automatic outcome_t resolve_pair(pair_t p);
        outcome_t        o;
        longint          pax, pay, vax, vay, pbx, pby, vbx, vby;
        longint          dx, dy, nx, ny, pen, fa, fb, rs, e, s, t, ta, tb, ca, cb, h;
        longint unsigned adx, ady, cdl, sq, root_dist, ma, mb, msum;
        bit              both_solid, gas_pair, has_liquid, contact, impulse;
        pax = p.pax; pay = p.pay; vax = p.vax; vay = p.vay;
        pbx = p.pbx; pby = p.pby; vbx = p.vbx; vby = p.vby;
        ma = p.ma;
        mb = p.mb;
        cdl = contact_dist;
        dx = pbx - pax;
        dy = pby - pay;
        adx = magnitude(dx);
        ady = magnitude(dy);
        contact = 1'b0;
        impulse = 1'b0;
        if (adx < cdl && ady < cdl && adx * adx + ady * ady < cdl * cdl)
        begin
            contact = 1'b1;
            sq = adx * adx + ady * ady;
            root_dist = (sq == 0) ? cdl : int_sqrt(sq);
            nx = longint'((adx << FRAC_W) / root_dist);
            ny = longint'((ady << FRAC_W) / root_dist);
            if (dx < 0)
                nx = -nx;
            if (dy < 0)
                ny = -ny;
            pen = longint'(cdl - root_dist);
            msum = ma + mb;
            if (msum == 0)
            begin
                fa = 64'sd1 << (FRAC_W - 1);
                fb = fa;
            end
            else
            begin
                fa = longint'((mb << FRAC_W) / msum);
                fb = longint'((ma << FRAC_W) / msum);
            end
            both_solid = (p.pha == PHASE_SOLID && p.phb == PHASE_SOLID);
            gas_pair = (p.pha == PHASE_GAS && p.phb == PHASE_GAS)
                    || (p.pha == PHASE_SOLID && p.phb == PHASE_GAS)
                    || (p.pha == PHASE_GAS && p.phb == PHASE_SOLID);
            has_liquid = (p.pha == PHASE_LIQUID && p.phb != PHASE_SPARE)
                      || (p.phb == PHASE_LIQUID && p.pha != PHASE_SPARE);
            if (both_solid || gas_pair)
            begin
                rs = (vbx - vax) * nx + (vby - vay) * ny;
                if (rs < 0)
                begin
                    e = both_solid ? longint'(rest_solid) : longint'(rest_gas);
                    s = longint'((64'd0 - longint'(rs)) >> FRAC_W);
                    t = qmul(s, (64'sd1 << FRAC_W) + e);
                    ta = qmul(t, fa);
                    tb = qmul(t, fb);
                    impulse = 1'b1;
                    vax = vax - qmul(ta, nx);
                    vay = vay - qmul(ta, ny);
                    vbx = vbx + qmul(tb, nx);
                    vby = vby + qmul(tb, ny);
                    if (both_solid)
                    begin
                        ca = longint'((longint'(pen) * longint'(fa)) >> (FRAC_W + 1));
                        cb = longint'((longint'(pen) * longint'(fb)) >> (FRAC_W + 1));
                        pax = pax - qmul(ca, nx);
                        pay = pay - qmul(ca, ny);
                        pbx = pbx + qmul(cb, nx);
                        pby = pby + qmul(cb, ny);
                    end
                end
            end
            else if (has_liquid)
            begin
                h = pen >>> 1;
                pax = pax - qmul(h, nx);
                pay = pay - qmul(h, ny);
                pbx = pbx + qmul(h, nx);
                pby = pby + qmul(h, ny);
            end
        end
        o.w = '{clamp_word(pax), clamp_word(pay), clamp_word(vax), clamp_word(vay),
                clamp_word(pbx), clamp_word(pby), clamp_word(vbx), clamp_word(vby)};
        o.contact = contact;
        o.impulse = impulse;
        return o;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_pair(pair_t p);
        return {4'b0, p.phb, p.mb, p.vby, p.vbx, p.pby, p.pbx,
                p.pha, p.ma, p.vay, p.vax, p.pay, p.pax};
    endfunction

    function automatic pair_t make_pair(longint pax, longint pay, longint vax, longint vay,
                                        longint ma, logic [1:0] pha,
                                        longint pbx, longint pby, longint vbx, longint vby,
                                        longint mb, logic [1:0] phb);
        pair_t p;
        p.pax = pax[31:0]; p.pay = pay[31:0]; p.vax = vax[31:0]; p.vay = vay[31:0];
        p.ma = ma[31:0];   p.pha = pha;
        p.pbx = pbx[31:0]; p.pby = pby[31:0]; p.vbx = vbx[31:0]; p.vby = vby[31:0];
        p.mb = mb[31:0];   p.phb = phb;
        return p;
    endfunction

    // Directed rows; a typed expectation only where the result is plain.
    task automatic add_row(pair_t p, logic typed, logic contact);
        row_t r;
        r.p = p;
        r.typed = typed;
        r.res = unchanged_pair(p, contact);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // Random pair: mostly near neighbours around the contact distance, some noise.
    function automatic pair_t random_pair();
        pair_t  p;
        longint span, ox, oy;
        p.pax = $urandom;
        p.pay = $urandom;
        p.vax = $urandom;
        p.vay = $urandom;
        p.ma  = $urandom;
        p.mb  = $urandom;
        p.pha = 2'($urandom_range(0, 3));
        p.phb = 2'($urandom_range(0, 3));
        p.pbx = $urandom;
        p.pby = $urandom;
        p.vbx = $urandom;
        p.vby = $urandom;
        if ($urandom_range(0, 9) < 8)
        begin
            span = longint'(contact_dist) + longint'(contact_dist) / 4;
            if (span > 64'sd2147483647)
                span = 64'sd2147483647;
            ox = longint'($urandom_range(0, 32'(2 * span))) - span;
            oy = longint'($urandom_range(0, 32'(2 * span))) - span;
            if ($urandom_range(0, 3) != 0)
            begin
                p.pax = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
                p.pay = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            end
            p.pbx = p.pax + ox[31:0];
            p.pby = p.pay + oy[31:0];
            if ($urandom_range(0, 3) != 0)
            begin
                p.vax = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
                p.vay = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
                p.vbx = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
                p.vby = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
                p.ma  = $urandom_range(1, 32'h0010_0000);
                p.mb  = $urandom_range(1, 32'h0010_0000);
            end
            if ($urandom_range(0, 9) != 0)
            begin
                p.pha = 2'($urandom_range(0, 2));
                p.phb = 2'($urandom_range(0, 2));
            end
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: may idle at random first, offers one pair, holds it until accepted.
    // ------------------------------------------------------------------------
    task automatic offer_pair(pair_t p, logic typed, outcome_t res);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        offered_pair = p;
        offered_typed = typed;
        offered_outcome = res;
        s_tdata <= pack_pair(p);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        @(negedge clk);
    endtask

    // Register writes happen only once the pipeline has drained.
    task automatic write_settings(logic [CD_W-1:0] cd, logic [REST_W-1:0] es,
                                  logic [REST_W-1:0] eg);
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CONTACT_DISTANCE;
        cfg_data <= cd;
        contact_dist = cd;
        @(negedge clk);
        cfg_index <= CFG_SOLID_RESTITUTION;
        cfg_data <= CFG_DATA_W'(es);
        rest_solid = es;
        @(negedge clk);
        cfg_index <= CFG_GAS_RESTITUTION;
        cfg_data <= CFG_DATA_W'(eg);
        rest_gas = eg;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Main stimulus sequence.
    initial
    begin
        logic [CD_W-1:0]   set_cd [N_SETTINGS];
        logic [REST_W-1:0] set_es [N_SETTINGS];
        logic [REST_W-1:0] set_eg [N_SETTINGS];
        outcome_t          unused;

        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_CONTACT_DISTANCE;
        cfg_data = '0;
        no_idle = 1'b0;
        hold_left = 0;
        errors = 0;
        contact_dist = CD_RESET;
        rest_solid = SOLID_REST_RESET;
        rest_gas = GAS_REST_RESET;
        unused = unchanged_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);

        // Far apart, and full-scale fields far apart.
        add_row(make_pair(0, 0, 65536, 0, 65536, PHASE_SOLID,
                          655360, 0, -65536, 0, 65536, PHASE_SOLID), 1'b1, 1'b0);
        add_row(make_pair(-2147483648, -2147483648, 2147483647, -2147483648,
                          64'hFFFF_FFFF, PHASE_LIQUID,
                          2147483647, 2147483647, -2147483648, 2147483647,
                          64'hFFFF_FFFF, PHASE_GAS), 1'b1, 1'b0);
        // Offset exactly at the contact distance is not a contact.
        add_row(make_pair(0, 0, 65536, 0, 65536, PHASE_SOLID,
                          131072, 0, -65536, 0, 65536, PHASE_SOLID), 1'b1, 1'b0);
        // Zero offset: in contact but nothing moves.
        add_row(make_pair(4096, -4096, 65536, 0, 65536, PHASE_SOLID,
                          4096, -4096, -65536, 0, 65536, PHASE_SOLID), 1'b1, 1'b1);
        add_row(make_pair(2147483647, -2147483648, -2147483648, 2147483647,
                          1, PHASE_LIQUID,
                          2147483647, -2147483648, 2147483647, -2147483648,
                          64'hFFFF_FFFF, PHASE_GAS), 1'b1, 1'b1);
        // Unused phase code: contact reported, nothing moves.
        add_row(make_pair(0, 0, 65536, 0, 65536, PHASE_SPARE,
                          65536, 0, -65536, 0, 65536, PHASE_SOLID), 1'b1, 1'b1);
        // Every phase combination: closing, separating and at rest.
        add_row(make_pair(0, 0, 65536, 0, 65536, PHASE_SOLID,
                          65536, 0, -65536, 0, 65536, PHASE_SOLID), 1'b0, 1'b0);
        add_row(make_pair(0, 0, -65536, 0, 65536, PHASE_SOLID,
                          65536, 0, 65536, 0, 65536, PHASE_SOLID), 1'b0, 1'b0);
        add_row(make_pair(0, 0, 65536, 32768, 65536, PHASE_GAS,
                          40000, 50000, -65536, 0, 131072, PHASE_GAS), 1'b0, 1'b0);
        add_row(make_pair(0, 0, 65536, 0, 196608, PHASE_SOLID,
                          -30000, -70000, -65536, -65536, 65536, PHASE_GAS), 1'b0, 1'b0);
        add_row(make_pair(0, 0, 65536, 0, 65536, PHASE_GAS,
                          90000, -20000, -65536, 0, 65536, PHASE_SOLID), 1'b0, 1'b0);
        add_row(make_pair(0, 0, 0, 0, 65536, PHASE_LIQUID,
                          65536, 65536, 0, 0, 65536, PHASE_SOLID), 1'b0, 1'b0);
        add_row(make_pair(0, 0, 0, 0, 65536, PHASE_LIQUID,
                          -100000, 3, 0, 0, 65536, PHASE_LIQUID), 1'b0, 1'b0);
        add_row(make_pair(0, 0, 0, 0, 65536, PHASE_GAS,
                          5, -5, 0, 0, 65536, PHASE_LIQUID), 1'b0, 1'b0);
        // Zero masses share evenly; a tiny mass against the largest.
        add_row(make_pair(0, 0, 65536, 0, 0, PHASE_SOLID,
                          65536, 0, -65536, 0, 0, PHASE_SOLID), 1'b0, 1'b0);
        add_row(make_pair(0, 0, 65536, 0, 1, PHASE_SOLID,
                          65536, 0, -65536, 0, 64'hFFFF_FFFF, PHASE_SOLID), 1'b0, 1'b0);
        // Saturation of positions and velocities.
        add_row(make_pair(2147418112, 0, 0, 0, 65536, PHASE_LIQUID,
                          2147483647, 0, 0, 0, 65536, PHASE_LIQUID), 1'b0, 1'b0);
        add_row(make_pair(-2147483648, 0, 2147483647, 0, 65536, PHASE_SOLID,
                          -2147450880, 0, -2147483648, 0, 65536, PHASE_SOLID), 1'b0, 1'b0);
        add_row(make_pair(0, 0, 2147483647, 2147483647, 65536, PHASE_GAS,
                          -1, -1, -2147483648, -2147483648, 65536, PHASE_GAS), 1'b0, 1'b0);

        @(posedge rst_n);
        @(negedge clk);
        foreach (directed_rows[i])
            offer_pair(directed_rows[i].p, directed_rows[i].typed, directed_rows[i].res);

        // Register settings, extremes among them.
        set_cd = '{31'd1, 31'h7FFF_FFFF, 31'd0, 31'd65536, 31'd524288, CD_RESET};
        set_es = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768, 17'd65535, SOLID_REST_RESET};
        set_eg = '{17'd65536, 17'd0, 17'h1FFFF, 17'd16384, 17'd1, GAS_REST_RESET};
        for (int k = 0; k < N_SETTINGS; k++)
        begin
            write_settings(set_cd[k], set_es[k], set_eg[k]);
            no_idle = (k == 3);
            if (k == 1)
                hold_left = 250;
            for (int n = 0; n < PAIRS_PER_SET; n++)
                offer_pair(random_pair(), 1'b0, unused);
        end

        // Drain and let the pipeline settle.
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: idles at random after each transaction, plus one long hold-off.
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        recv_gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (recv_gap > 0)
            begin
                m_tready <= 1'b0;
                recv_gap = recv_gap - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Checker and watchdog, sampled at the rising edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t want;
        logic [31:0] got_word;
        if (rst_n)
        begin
            quiet_cycles = quiet_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                quiet_cycles = 0;
                recv_gap = no_idle ? 0 : $urandom_range(0, 5);
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    for (int i = 0; i < 8; i++)
                    begin
                        got_word = m_tdata[32*i +: 32];
                        if (got_word !== want.w[i])
                        begin
                            $display("%0t: %s expected %h actual %h", $time,
                                     word_names[i], want.w[i], got_word);
                            errors++;
                        end
                    end
                    if (m_tdata[256] !== want.contact)
                    begin
                        $display("%0t: in_contact expected %b actual %b", $time,
                                 want.contact, m_tdata[256]);
                        errors++;
                    end
                    if (m_tdata[257] !== want.impulse)
                    begin
                        $display("%0t: impulse_applied expected %b actual %b", $time,
                                 want.impulse, m_tdata[257]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                quiet_cycles = 0;
                if (offered_typed)
                    pending_outcomes.insert(pending_outcomes.size(), offered_outcome);
                else
                    pending_outcomes.insert(pending_outcomes.size(),
                                            resolve_pair(offered_pair));
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
        else
            quiet_cycles = 0;
    end

endmodule
